[sv/voxel_face_culling_mesher_defines.svh]
// assertion macros for the voxel mesher
`ifndef VOXEL_FACE_CULLING_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_DEFINES_SVH

`ifndef SYNTHESIS
`define VFCM_ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VFCM_ASSERT(label, prop, msg) \
  `VFCM_ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define VFCM_ASSERT_AT(label, clk, rstn, prop, msg)
`define VFCM_ASSERT(label, prop, msg)
`endif

`endif

[sv/vfcm_pkg.sv]
package vfcm_pkg;

  localparam int CHUNK_EDGE_DEF = 16;

  localparam int COORD_W  = 4;
  localparam int BLOCK_W  = 5;
  localparam int QUAD_W   = 5;
  localparam int DIR_W    = 3;
  localparam int VBASE_W  = 17;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_FACES = 6;

  localparam logic [VBASE_W-1:0] VERTS_PER_QUAD = VBASE_W'(4);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AIR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WATER = CFG_IDX_W'(1);

  localparam logic [BLOCK_W-1:0] AIR_RST   = BLOCK_W'(0);
  localparam logic [BLOCK_W-1:0] WATER_RST = BLOCK_W'(9);

  // face direction codes
  localparam logic [DIR_W-1:0] FACE_PZ = DIR_W'(0);
  localparam logic [DIR_W-1:0] FACE_NZ = DIR_W'(1);
  localparam logic [DIR_W-1:0] FACE_PX = DIR_W'(2);
  localparam logic [DIR_W-1:0] FACE_NX = DIR_W'(3);
  localparam logic [DIR_W-1:0] FACE_PY = DIR_W'(4);
  localparam logic [DIR_W-1:0] FACE_NY = DIR_W'(5);

  typedef struct packed {
    logic clear_step;
    logic take;
    logic center;
    logic scan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic mesh_go;
    logic solid;
    logic scan_done;
    logic any_face;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

  // origin corner offsets per face
  function automatic logic corner_dx(logic [DIR_W-1:0] d);
    return (d == FACE_NZ) || (d == FACE_PX);
  endfunction

  function automatic logic corner_dy(logic [DIR_W-1:0] d);
    return (d == FACE_PY);
  endfunction

  function automatic logic corner_dz(logic [DIR_W-1:0] d);
    return (d == FACE_PZ) || (d == FACE_NX) || (d == FACE_NY);
  endfunction

endpackage

[sv/vfcm_ram.sv]
module vfcm_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/vfcm_ctrl.sv]
module vfcm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vfcm_pkg::ctrl_sts_t sts_i,
  output vfcm_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CENTER = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && sts_i.mesh_go) state_d = S_CENTER;
      end
      S_CENTER: begin
        cmd_o.center = 1'b1;
        state_d = sts_i.solid ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = sts_i.any_face ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
        if (sts_i.out_free && sts_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/vfcm_datapath.sv]
module vfcm_datapath #(
  parameter int CHUNK_EDGE = vfcm_pkg::CHUNK_EDGE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vfcm_pkg::ctrl_cmd_t                 cmd_i,
  output vfcm_pkg::ctrl_sts_t                 sts_o,
  input  logic                                cfg_we_i,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [vfcm_pkg::BLOCK_W-1:0]        cfg_data_i,
  input  logic                                kind_i,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_x_i,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_y_i,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_z_i,
  input  logic [vfcm_pkg::BLOCK_W-1:0]        block_value_i,
  input  logic                                restart_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [vfcm_pkg::QUAD_W-1:0]         quad_x_o,
  output logic [vfcm_pkg::QUAD_W-1:0]         quad_y_o,
  output logic [vfcm_pkg::QUAD_W-1:0]         quad_z_o,
  output logic [vfcm_pkg::DIR_W-1:0]          face_dir_o,
  output logic [vfcm_pkg::BLOCK_W-1:0]        face_block_o,
  output logic [vfcm_pkg::VBASE_W-1:0]        vertex_base_o,
  output logic                                last_face_o
);

  localparam int CW    = $clog2(CHUNK_EDGE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NF    = vfcm_pkg::NUM_FACES;

  logic [vfcm_pkg::BLOCK_W-1:0] air_q, water_q;
  logic [AW-1:0]                clr_q;
  logic [vfcm_pkg::COORD_W-1:0] x_q, y_q, z_q;
  logic [vfcm_pkg::BLOCK_W-1:0] code_q;
  logic [vfcm_pkg::DIR_W-1:0]   d_q;
  logic [NF-1:0]                mask_q;
  logic [vfcm_pkg::VBASE_W-1:0] vcnt_q;
  logic                         out_valid_q;

  logic [vfcm_pkg::QUAD_W-1:0]  qx_q, qy_q, qz_q;
  logic [vfcm_pkg::DIR_W-1:0]   qdir_q;
  logic [vfcm_pkg::BLOCK_W-1:0] qblk_q;
  logic [vfcm_pkg::VBASE_W-1:0] qvb_q;
  logic                         qlast_q;

  logic                         mem_we;
  logic [AW-1:0]                mem_addr;
  logic [vfcm_pkg::BLOCK_W-1:0] mem_wdata, mem_rdata;

  logic                         in_chunk;
  logic [vfcm_pkg::DIR_W-1:0]   dir_next;
  logic [CW-1:0]                xc, yc, zc, nx, ny, nz;
  logic                         oob;
  logic                         see_thru;
  logic [NF-1:0]                mask_new;
  logic [vfcm_pkg::DIR_W-1:0]   sel;
  logic [NF-1:0]                sel_hot;
  logic [NF-1:0]                rem_after;
  logic                         out_free;

  assign in_chunk = (32'(cell_x_i) < CHUNK_EDGE) && (32'(cell_y_i) < CHUNK_EDGE) &&
                    (32'(cell_z_i) < CHUNK_EDGE);

  assign xc = CW'(x_q);
  assign yc = CW'(y_q);
  assign zc = CW'(z_q);

  // neighbour whose read goes out this cycle
  assign dir_next = cmd_i.center ? vfcm_pkg::FACE_PZ : d_q + vfcm_pkg::DIR_W'(1);

  always_comb begin
    nx = xc;
    ny = yc;
    nz = zc;
    unique case (dir_next)
      vfcm_pkg::FACE_PZ: nz = zc + CW'(1);
      vfcm_pkg::FACE_NZ: nz = zc - CW'(1);
      vfcm_pkg::FACE_PX: nx = xc + CW'(1);
      vfcm_pkg::FACE_NX: nx = xc - CW'(1);
      vfcm_pkg::FACE_PY: ny = yc + CW'(1);
      vfcm_pkg::FACE_NY: ny = yc - CW'(1);
      default: ;
    endcase
  end

  // neighbour of the face under test lies outside the chunk
  always_comb begin
    unique case (d_q)
      vfcm_pkg::FACE_PZ: oob = (32'(z_q) == CHUNK_EDGE - 1);
      vfcm_pkg::FACE_NZ: oob = (z_q == '0);
      vfcm_pkg::FACE_PX: oob = (32'(x_q) == CHUNK_EDGE - 1);
      vfcm_pkg::FACE_NX: oob = (x_q == '0);
      vfcm_pkg::FACE_PY: oob = (32'(y_q) == CHUNK_EDGE - 1);
      vfcm_pkg::FACE_NY: oob = (y_q == '0);
      default:           oob = 1'b0;
    endcase
  end

  assign see_thru = oob || (mem_rdata == air_q) || (mem_rdata == water_q);
  assign mask_new = mask_q | (NF'(see_thru) << d_q);

  always_comb begin
    sel = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = vfcm_pkg::DIR_W'(i);
    end
  end

  assign sel_hot   = NF'(1) << sel;
  assign rem_after = mask_q & ~sel_hot;
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = block_value_i;
    mem_addr  = {CW'(cell_x_i), CW'(cell_y_i), CW'(cell_z_i)};
    if (cmd_i.clear_step) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
      mem_addr  = clr_q;
    end else if (cmd_i.center || cmd_i.scan) begin
      mem_addr = {nx, ny, nz};
    end else begin
      mem_we = cmd_i.take && !kind_i && in_chunk;
    end
  end

  vfcm_ram #(
    .WIDTH (vfcm_pkg::BLOCK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      air_q       <= vfcm_pkg::AIR_RST;
      water_q     <= vfcm_pkg::WATER_RST;
      clr_q       <= '0;
      vcnt_q      <= '0;
      d_q         <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == vfcm_pkg::CFG_AIR)   air_q   <= cfg_data_i;
        if (cfg_index_i == vfcm_pkg::CFG_WATER) water_q <= cfg_data_i;
      end
      if (cmd_i.clear_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.take && kind_i && restart_i) vcnt_q <= '0;
      if (cmd_i.center) begin
        d_q    <= '0;
        mask_q <= '0;
      end
      if (cmd_i.scan) begin
        d_q    <= d_q + vfcm_pkg::DIR_W'(1);
        mask_q <= mask_new;
      end
      if (cmd_i.emit) begin
        mask_q <= rem_after;
        vcnt_q <= vcnt_q + vfcm_pkg::VERTS_PER_QUAD;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and quad payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      x_q <= cell_x_i;
      y_q <= cell_y_i;
      z_q <= cell_z_i;
    end
    if (cmd_i.center) code_q <= mem_rdata;
    if (cmd_i.emit) begin
      qx_q    <= {1'b0, x_q} + vfcm_pkg::QUAD_W'(vfcm_pkg::corner_dx(sel));
      qy_q    <= {1'b0, y_q} + vfcm_pkg::QUAD_W'(vfcm_pkg::corner_dy(sel));
      qz_q    <= {1'b0, z_q} + vfcm_pkg::QUAD_W'(vfcm_pkg::corner_dz(sel));
      qdir_q  <= sel;
      qblk_q  <= code_q;
      qvb_q   <= vcnt_q;
      qlast_q <= (rem_after == '0);
    end
  end

  assign sts_o.clear_done = (clr_q == {AW{1'b1}});
  assign sts_o.mesh_go    = kind_i && in_chunk;
  assign sts_o.solid      = (mem_rdata != air_q);
  assign sts_o.scan_done  = (d_q == vfcm_pkg::FACE_NY);
  assign sts_o.any_face   = (mask_new != '0);
  assign sts_o.emit_last  = (rem_after == '0);
  assign sts_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign quad_x_o      = qx_q;
  assign quad_y_o      = qy_q;
  assign quad_z_o      = qz_q;
  assign face_dir_o    = qdir_q;
  assign face_block_o  = qblk_q;
  assign vertex_base_o = qvb_q;
  assign last_face_o   = qlast_q;

endmodule

[sv/voxel_face_culling_mesher.sv]
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_stall_o   kind, cell_x/y/z, block_value, restart
// output    out        out_valid_o / out_stall_i quad_x/y/z, face_dir, face_block,
//                                                vertex_base, last_face
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// a write request is stored when taken; a mesh request reads the centre cell and, on a solid
// cell, the six neighbours in turn from the single-port store, then emits one quad per
// visible face; an air cell ends the request after the centre read.
// after reset the store is swept to zero, one entry a cycle, over all CHUNK_EDGE
// rounded up to a power of two, cubed, entries (4096 by default); input stalls.
// a stalled output holds the quad and pauses emission; config is always ready.
`include "voxel_face_culling_mesher_defines.svh"

module voxel_face_culling_mesher #(
  parameter int CHUNK_EDGE = vfcm_pkg::CHUNK_EDGE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vfcm_pkg::BLOCK_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           kind_i,
  input  logic [vfcm_pkg::COORD_W-1:0]   cell_x_i,
  input  logic [vfcm_pkg::COORD_W-1:0]   cell_y_i,
  input  logic [vfcm_pkg::COORD_W-1:0]   cell_z_i,
  input  logic [vfcm_pkg::BLOCK_W-1:0]   block_value_i,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vfcm_pkg::QUAD_W-1:0]    quad_x_o,
  output logic [vfcm_pkg::QUAD_W-1:0]    quad_y_o,
  output logic [vfcm_pkg::QUAD_W-1:0]    quad_z_o,
  output logic [vfcm_pkg::DIR_W-1:0]     face_dir_o,
  output logic [vfcm_pkg::BLOCK_W-1:0]   face_block_o,
  output logic [vfcm_pkg::VBASE_W-1:0]   vertex_base_o,
  output logic                           last_face_o
);

  vfcm_pkg::ctrl_cmd_t cmd;
  vfcm_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  vfcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfcm_datapath #(
    .CHUNK_EDGE (CHUNK_EDGE)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .cell_x_i      (cell_x_i),
    .cell_y_i      (cell_y_i),
    .cell_z_i      (cell_z_i),
    .block_value_i (block_value_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .quad_x_o      (quad_x_o),
    .quad_y_o      (quad_y_o),
    .quad_z_o      (quad_z_o),
    .face_dir_o    (face_dir_o),
    .face_block_o  (face_block_o),
    .vertex_base_o (vertex_base_o),
    .last_face_o   (last_face_o)
  );

  // a quad loaded by the emitter shows up on the output
  `VFCM_ASSERT(a_emit_shows, cmd.emit |=> out_valid_o, "emitted quad not presented")
  // no request taken and no quad shown while the store is swept
  `VFCM_ASSERT(a_clear_quiet, cmd.clear_step |-> (in_stall_o && !out_valid_o), "activity during sweep")
  // after the final quad the block takes requests again
  `VFCM_ASSERT(a_last_frees, (cmd.emit && sts.emit_last) |=> !in_stall_o, "not ready after last quad")

endmodule
